/* rtl/core/sic_pkg.sv */
package sic_pkg;

    // sizing defaults
    localparam int DEF_NUM_SOURCES = 16;
    localparam int DEF_NUM_VECTORS = 256;

    // operation codes
    localparam logic [2:0] FN_WRITE   = 3'd0;
    localparam logic [2:0] FN_READ    = 3'd1;
    localparam logic [2:0] FN_DELIVER = 3'd2;
    localparam logic [2:0] FN_QUERY   = 3'd3;
    localparam logic [2:0] FN_ACK     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_EXC = 2'd1;
    localparam logic [1:0] ST_FWD = 2'd2;

    // register numbers
    localparam logic [31:0] R_EOI      = 32'h4000_0070;
    localparam logic [31:0] R_ICR      = 32'h4000_0071;
    localparam logic [31:0] R_TPR      = 32'h4000_0072;
    localparam logic [31:0] R_VPA      = 32'h4000_0073;
    localparam logic [31:0] R_SCONTROL = 32'h4000_0080;
    localparam logic [31:0] R_SVERSION = 32'h4000_0081;
    localparam logic [31:0] R_SIEFP    = 32'h4000_0082;
    localparam logic [31:0] R_SIMP     = 32'h4000_0083;
    localparam logic [31:0] R_EOM      = 32'h4000_0084;
    localparam logic [31:0] R_SINT0    = 32'h4000_0090;

    // SINT layout
    localparam int MASK_BIT = 16;
    localparam int AEOI_BIT = 17;
    localparam int POLL_BIT = 18;
    localparam logic [7:0] SINT_VEC_MIN = 8'h10;
    localparam logic [63:0] SVERSION_VAL = 64'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] reg_number;
        logic [63:0] write_data;
        logic [3:0]  source_index;
        logic        slot_busy;
        logic [31:0] timer_number;
        logic [63:0] expiry_time;
        logic [63:0] delivered_time;
        logic [7:0]  irq_vector_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_data;
        logic        delivered;
        logic        set_slot_pending;
        logic        raise_irq;
        logic [7:0]  irq_vector_out;
        logic        aeoi_flag;
        logic [31:0] msg_timer_number;
        logic [63:0] msg_expiry;
        logic [63:0] msg_delivery;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item, start the map read
        logic exec;   // commit state updates and load the result
    } t_dp_cmd;

endpackage

/* rtl/core/sic_chan_if.sv */
interface sic_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/sic_ram.sv */
module sic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/sic_ctrl.sv */
module sic_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sic_pkg::t_dp_cmd o_cmd
);
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept, w_exec;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    // result register must be free, or emptying this cycle
    assign w_exec   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = w_exec || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = w_accept;
    assign o_cmd.exec  = w_exec;
endmodule

/* rtl/core/sic_datapath.sv */
module sic_datapath #(
    parameter int NUM_SOURCES = sic_pkg::DEF_NUM_SOURCES,
    parameter int NUM_VECTORS = sic_pkg::DEF_NUM_VECTORS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sic_pkg::t_dp_cmd  i_cmd,
    input  sic_pkg::t_in_item i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    output sic_pkg::t_out_item o_item
);
    localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int VEC_AW = $clog2(NUM_VECTORS);

    // architectural state
    logic [63:0]            r_src [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_pending, n_pending;
    logic [63:0]            r_ctl, r_efp, r_simp, r_vpa;
    logic                   r_enable;
    logic [NUM_VECTORS-1:0] r_map_vld, n_map_vld;

    // item and result holding
    sic_pkg::t_in_item  r_item;
    sic_pkg::t_out_item r_out, n_out;

    logic [SRC_W-1:0]  w_map_idx, w_sx, w_sint_idx, w_addr;
    logic [31:0]       w_off;
    logic              w_sint_hit, w_sx_ok, w_mapped;
    logic [63:0]       w_src;
    logic [VEC_AW-1:0] w_old_vec, w_new_vec;
    logic              we_vpa, we_ctl, we_efp, we_simp, we_sint;

    // vector -> source map; an entry without its valid bit is unmapped
    sic_ram #(
        .WIDTH (SRC_W),
        .DEPTH (NUM_VECTORS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && we_sint),
        .i_waddr (w_new_vec),
        .i_wdata (w_sint_idx),
        .i_re    (i_cmd.load),
        .i_raddr (i_item.irq_vector_in[VEC_AW-1:0]),
        .o_rdata (w_map_idx)
    );

    assign w_off      = r_item.reg_number - sic_pkg::R_SINT0;
    assign w_sint_hit = (r_item.reg_number >= sic_pkg::R_SINT0) &&
                        (w_off < 32'(NUM_SOURCES));
    assign w_sint_idx = w_off[SRC_W-1:0];
    assign w_sx_ok    = 32'(r_item.source_index) < 32'(NUM_SOURCES);
    assign w_sx       = r_item.source_index[SRC_W-1:0];
    assign w_mapped   = r_map_vld[r_item.irq_vector_in[VEC_AW-1:0]];
    assign w_new_vec  = r_item.write_data[VEC_AW-1:0];

    always_comb begin
        case (r_item.func)
            sic_pkg::FN_QUERY, sic_pkg::FN_ACK: w_addr = w_map_idx;
            sic_pkg::FN_DELIVER:                w_addr = w_sx;
            default:                            w_addr = w_sint_idx;
        endcase
    end

    assign w_src     = r_src[w_addr];
    assign w_old_vec = w_src[VEC_AW-1:0];

    always_comb begin
        n_out     = '0;
        n_pending = r_pending;
        n_map_vld = r_map_vld;
        we_vpa    = 1'b0;
        we_ctl    = 1'b0;
        we_efp    = 1'b0;
        we_simp   = 1'b0;
        we_sint   = 1'b0;
        case (r_item.func)
            sic_pkg::FN_WRITE: begin
                case (r_item.reg_number)
                    sic_pkg::R_EOI, sic_pkg::R_ICR, sic_pkg::R_TPR: begin
                        n_out.status = sic_pkg::ST_FWD;
                    end
                    sic_pkg::R_VPA: begin
                        we_vpa = 1'b1;
                    end
                    sic_pkg::R_SVERSION: begin
                        n_out.status = sic_pkg::ST_EXC;
                    end
                    sic_pkg::R_SCONTROL, sic_pkg::R_SIEFP,
                    sic_pkg::R_SIMP, sic_pkg::R_EOM: begin
                        if (!r_enable) begin
                            n_out.status = sic_pkg::ST_EXC;
                        end else if (r_item.reg_number == sic_pkg::R_SCONTROL) begin
                            we_ctl = 1'b1;
                        end else if (r_item.reg_number == sic_pkg::R_SIEFP) begin
                            we_efp = 1'b1;
                        end else if (r_item.reg_number == sic_pkg::R_SIMP) begin
                            we_simp = 1'b1;
                        end else begin
                            n_pending = '0;
                        end
                    end
                    default: begin
                        if (!w_sint_hit || !r_enable ||
                            (r_item.write_data[7:0] < sic_pkg::SINT_VEC_MIN)) begin
                            n_out.status = sic_pkg::ST_EXC;
                        end else begin
                            we_sint = 1'b1;
                            // old vector unmapped first; new mapping wins if equal
                            n_map_vld[w_old_vec] = 1'b0;
                            n_map_vld[w_new_vec] = 1'b1;
                            if (r_item.write_data[sic_pkg::POLL_BIT]) begin
                                n_pending[w_sint_idx] = 1'b0;
                            end
                        end
                    end
                endcase
            end
            sic_pkg::FN_READ: begin
                case (r_item.reg_number)
                    sic_pkg::R_EOI: begin
                        n_out.status = sic_pkg::ST_EXC;
                    end
                    sic_pkg::R_ICR, sic_pkg::R_TPR: begin
                        n_out.status = sic_pkg::ST_FWD;
                    end
                    sic_pkg::R_VPA: begin
                        n_out.read_data = r_vpa;
                    end
                    sic_pkg::R_SCONTROL, sic_pkg::R_SVERSION, sic_pkg::R_SIEFP,
                    sic_pkg::R_SIMP, sic_pkg::R_EOM: begin
                        if (!r_enable) begin
                            n_out.status = sic_pkg::ST_EXC;
                        end else if (r_item.reg_number == sic_pkg::R_SCONTROL) begin
                            n_out.read_data = r_ctl;
                        end else if (r_item.reg_number == sic_pkg::R_SVERSION) begin
                            n_out.read_data = sic_pkg::SVERSION_VAL;
                        end else if (r_item.reg_number == sic_pkg::R_SIEFP) begin
                            n_out.read_data = r_efp;
                        end else if (r_item.reg_number == sic_pkg::R_SIMP) begin
                            n_out.read_data = r_simp;
                        end
                    end
                    default: begin
                        if (!w_sint_hit || !r_enable) begin
                            n_out.status = sic_pkg::ST_EXC;
                        end else begin
                            n_out.read_data = w_src;
                        end
                    end
                endcase
            end
            sic_pkg::FN_DELIVER: begin
                if (w_sx_ok && !r_pending[w_sx]) begin
                    if (r_item.slot_busy) begin
                        n_out.set_slot_pending = 1'b1;
                        n_pending[w_sx]        = 1'b1;
                    end else begin
                        n_out.delivered        = 1'b1;
                        n_out.msg_timer_number = r_item.timer_number;
                        n_out.msg_expiry       = r_item.expiry_time;
                        n_out.msg_delivery     = r_item.delivered_time;
                        if (!w_src[sic_pkg::MASK_BIT]) begin
                            n_out.raise_irq      = 1'b1;
                            n_out.irq_vector_out = w_src[7:0];
                        end
                    end
                end
            end
            sic_pkg::FN_QUERY: begin
                if (w_mapped) begin
                    n_out.aeoi_flag = w_src[sic_pkg::AEOI_BIT];
                end
            end
            sic_pkg::FN_ACK: begin
                if (w_mapped) begin
                    n_pending[w_map_idx] = 1'b0;
                end
            end
            default: begin
                n_out.status = sic_pkg::ST_EXC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_src[i] <= 64'd1 << sic_pkg::MASK_BIT;
            end
            r_pending <= '0;
            r_ctl     <= '0;
            r_efp     <= '0;
            r_simp    <= '0;
            r_vpa     <= '0;
            r_enable  <= 1'b0;
            r_map_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_pending <= n_pending;
                r_map_vld <= n_map_vld;
                if (we_vpa) begin
                    r_vpa <= r_item.write_data;
                end
                if (we_ctl) begin
                    r_ctl <= r_item.write_data;
                end
                if (we_efp) begin
                    r_efp <= r_item.write_data;
                end
                if (we_simp) begin
                    r_simp <= r_item.write_data;
                end
                if (we_sint) begin
                    r_src[w_sint_idx] <= r_item.write_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;
endmodule

/* rtl/core/synthetic_interrupt_controller.sv */
// A result is loaded into the output register in the execute state that follows
// acceptance, later only while the previous result still waits to be collected.
// One item at a time: the vector map RAM read (registered) is started on acceptance,
// and the decode and state update follow in the execute state.
// A result waiting on the output holds the next item in its execute cycle.
// Reset (synchronous, active low): sources masked, all vectors unmapped at once
// by clearing their valid bits, pending bits, page registers and enable cleared.
module synthetic_interrupt_controller #(
    parameter int NUM_SOURCES = sic_pkg::DEF_NUM_SOURCES,
    parameter int NUM_VECTORS = sic_pkg::DEF_NUM_VECTORS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sic_chan_if.sink   i_in,
    sic_chan_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);
    sic_pkg::t_dp_cmd   w_cmd;
    sic_pkg::t_out_item w_out_item;

    // Sequencer: idle (ready for an item) -> execute -> idle.
    // The output register sits between the two sides, so a new item is taken
    // while the previous result is still waiting to be collected.
    sic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // Register file, source table, vector map and pending bits.
    // The map lookup for query and acknowledge is started on the accept edge.
    sic_datapath #(
        .NUM_SOURCES (NUM_SOURCES),
        .NUM_VECTORS (NUM_VECTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_in.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_item      (w_out_item)
    );

    assign o_out.payload = w_out_item;

    // One item in flight: in the cycle after an accept, the input is closed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another in execution");

    // A delivered message never also asks for the pending flag, and is ok.
    a_deliver_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.delivered) |->
        (!o_out.payload.set_slot_pending && (o_out.payload.status == sic_pkg::ST_OK)))
        else $error("delivered item with pending flag or bad status");

    // An interrupt is only raised along with a delivered message.
    a_irq_needs_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.raise_irq) |-> o_out.payload.delivered)
        else $error("interrupt raised without message delivery");

    // Status is always one of the defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.payload.status == sic_pkg::ST_OK) ||
                         (o_out.payload.status == sic_pkg::ST_EXC) ||
                         (o_out.payload.status == sic_pkg::ST_FWD)))
        else $error("invalid status code");
endmodule

/* dv/synthetic_interrupt_controller_test.sv */
module synthetic_interrupt_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sic_pkg::*;

    // Run shape
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off, fills the block
    localparam int PHASE_ITEMS  = 275;   // six random phases, about 1650 items
    localparam int NUM_PHASES   = 6;
    localparam int GAP_PCT      = 23;    // idle chance per cycle on each side
    localparam int DRAIN_CYCLES = 4;     // settling margin before an enable write
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_REPORTS  = 10;

    localparam logic [4:0] NO_SOURCE = 5'd16;  // vector map entry: unmapped
    localparam logic [2:0] FN_SPARE  = 3'd7;   // an unused operation code

    localparam logic PHASE_EN [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    localparam logic [31:0] NAMED_REGS [9] = '{
        R_EOI, R_ICR, R_TPR, R_VPA, R_SCONTROL, R_SVERSION, R_SIEFP, R_SIMP, R_EOM
    };

    typedef struct {
        logic      en;     // enable setting the row runs under
        t_in_item  it;
        bit        typed;  // expectation written into the table
        t_out_item want;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic i_cfg_wdata;

    sic_chan_if #(.t_payload(t_in_item))  in_ch ();
    sic_chan_if #(.t_payload(t_out_item)) out_ch ();

    synthetic_interrupt_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the controller state
    // ------------------------------------------------------------------
    logic [63:0] sint_q [16];
    logic [4:0]  vmap [256];
    logic [15:0] pend_q;
    logic [63:0] scontrol_q, siefp_q, simp_q, vpa_q;
    logic        enable_q;

    t_out_item due_resp [$];   // responses owed by the block, oldest first

    // Item currently offered: directed rows may carry their own expectation
    bit        cur_typed;
    t_out_item cur_typed_resp;

    bit       calm;      // no idling on either side
    bit       hold_req;  // ask the receiver for a long hold-off
    logic [7:0] vec_pool [8];

    int fails;
    int n_items, n_results, n_irq, n_mark, n_exc, n_cfg;
    int func_seen [8];

    // Next state and response of the controller for one item.
    function automatic t_out_item synic_response(input t_in_item it);
        t_out_item  r;
        logic [3:0] sx;
        logic [4:0] m;
        logic       in_sint;
        r = '0;
        r.status = ST_OK;
        // SINT0 sits on a 16-aligned number, so the low nibble is the source
        sx = it.reg_number[3:0];
        in_sint = (it.reg_number >= R_SINT0) && (it.reg_number < R_SINT0 + 32'd16);
        m = vmap[it.irq_vector_in];
        case (it.func)
            FN_WRITE: begin
                case (it.reg_number)
                    R_EOI, R_ICR, R_TPR: r.status = ST_FWD;
                    R_VPA:      vpa_q = it.write_data;
                    R_SVERSION: r.status = ST_EXC;
                    R_SCONTROL, R_SIEFP, R_SIMP, R_EOM: begin
                        if (!enable_q) begin
                            r.status = ST_EXC;
                        end else if (it.reg_number == R_SCONTROL) begin
                            scontrol_q = it.write_data;
                        end else if (it.reg_number == R_SIEFP) begin
                            siefp_q = it.write_data;
                        end else if (it.reg_number == R_SIMP) begin
                            simp_q = it.write_data;
                        end else begin
                            pend_q = '0;
                        end
                    end
                    default: begin
                        if (!in_sint || !enable_q || it.write_data[7:0] < SINT_VEC_MIN) begin
                            r.status = ST_EXC;
                        end else begin
                            // old vector dropped first, even if shared with another source
                            vmap[sint_q[sx][7:0]] = NO_SOURCE;
                            vmap[it.write_data[7:0]] = {1'b0, sx};
                            if (it.write_data[POLL_BIT]) pend_q[sx] = 1'b0;
                            sint_q[sx] = it.write_data;
                        end
                    end
                endcase
            end
            FN_READ: begin
                case (it.reg_number)
                    R_EOI:        r.status = ST_EXC;
                    R_ICR, R_TPR: r.status = ST_FWD;
                    R_VPA:        r.read_data = vpa_q;
                    R_SCONTROL, R_SVERSION, R_SIEFP, R_SIMP, R_EOM: begin
                        if (!enable_q) begin
                            r.status = ST_EXC;
                        end else if (it.reg_number == R_SCONTROL) begin
                            r.read_data = scontrol_q;
                        end else if (it.reg_number == R_SVERSION) begin
                            r.read_data = SVERSION_VAL;
                        end else if (it.reg_number == R_SIEFP) begin
                            r.read_data = siefp_q;
                        end else if (it.reg_number == R_SIMP) begin
                            r.read_data = simp_q;
                        end
                    end
                    default: begin
                        if (!in_sint || !enable_q) r.status = ST_EXC;
                        else r.read_data = sint_q[sx];
                    end
                endcase
            end
            FN_DELIVER: begin
                // a source already pending swallows the message
                if (!pend_q[it.source_index]) begin
                    if (it.slot_busy) begin
                        r.set_slot_pending = 1'b1;
                        pend_q[it.source_index] = 1'b1;
                    end else begin
                        r.delivered = 1'b1;
                        r.msg_timer_number = it.timer_number;
                        r.msg_expiry = it.expiry_time;
                        r.msg_delivery = it.delivered_time;
                        if (!sint_q[it.source_index][MASK_BIT]) begin
                            r.raise_irq = 1'b1;
                            r.irq_vector_out = sint_q[it.source_index][7:0];
                        end
                    end
                end
            end
            FN_QUERY: begin
                if (m < NO_SOURCE) r.aeoi_flag = sint_q[m[3:0]][AEOI_BIT];
            end
            FN_ACK: begin
                if (m < NO_SOURCE) pend_q[m[3:0]] = 1'b0;
            end
            default: r.status = ST_EXC;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders for the directed table
    // ------------------------------------------------------------------
    function automatic t_in_item reg_op(logic [2:0] f, logic [31:0] r, logic [63:0] d);
        t_in_item it;
        it = '0;
        it.func = f;
        it.reg_number = r;
        it.write_data = d;
        return it;
    endfunction

    function automatic t_in_item msg_op(logic [3:0] sx, logic busy, logic [63:0] pl);
        t_in_item it;
        it = '0;
        it.func = FN_DELIVER;
        it.source_index = sx;
        it.slot_busy = busy;
        it.timer_number = pl[31:0];
        it.expiry_time = pl;
        it.delivered_time = pl;
        return it;
    endfunction

    function automatic t_in_item vec_op(logic [2:0] f, logic [7:0] v);
        t_in_item it;
        it = '0;
        it.func = f;
        it.irq_vector_in = v;
        return it;
    endfunction

    function automatic t_out_item status_only(logic [1:0] st, logic [63:0] rd);
        t_out_item r;
        r = '0;
        r.status = st;
        r.read_data = rd;
        return r;
    endfunction

    // Random item: mostly well-formed register traffic on the known numbers and
    // vectors from a small pool, so that mapped vectors get queried and acked.
    function automatic t_in_item rand_item();
        t_in_item it;
        int sel;
        int rsel;
        it.func = 3'($urandom_range(7));
        it.reg_number = $urandom;
        it.write_data = {$urandom, $urandom};
        it.source_index = 4'($urandom_range(15));
        it.slot_busy = 1'($urandom_range(1));
        it.timer_number = $urandom;
        it.expiry_time = {$urandom, $urandom};
        it.delivered_time = {$urandom, $urandom};
        it.irq_vector_in = 8'($urandom_range(255));
        sel = $urandom_range(99);
        if (sel < 30) it.func = FN_WRITE;
        else if (sel < 50) it.func = FN_READ;
        else if (sel < 75) it.func = FN_DELIVER;
        else if (sel < 85) it.func = FN_QUERY;
        else if (sel < 95) it.func = FN_ACK;
        // else: any code, the unused ones included
        if (it.func == FN_WRITE || it.func == FN_READ) begin
            rsel = $urandom_range(99);
            if (rsel < 65) begin
                it.reg_number = R_SINT0 + 32'($urandom_range(15));
                // mostly legal vectors, now and then one below the floor
                if ($urandom_range(9) == 0) it.write_data[7:0] = 8'($urandom_range(15));
                else it.write_data[7:0] = vec_pool[$urandom_range(7)];
                it.write_data[MASK_BIT] = ($urandom_range(99) < 30);
            end else if (rsel < 95) begin
                it.reg_number = NAMED_REGS[$urandom_range(8)];
            end else if (rsel < 97) begin
                it.reg_number = R_SINT0 + 32'($urandom_range(31, 16));
            end
        end
        if ((it.func == FN_QUERY || it.func == FN_ACK) && $urandom_range(4) != 0)
            it.irq_vector_in = vec_pool[$urandom_range(7)];
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("Mismatch in %s at %0t: expected %h, got %h", name, $realtime, e, a);
        end
    endtask

    task automatic check_result(input t_out_item e, input t_out_item a);
        check_field("status", e.status, a.status);
        check_field("read_data", e.read_data, a.read_data);
        check_field("delivered", e.delivered, a.delivered);
        check_field("set_slot_pending", e.set_slot_pending, a.set_slot_pending);
        check_field("raise_irq", e.raise_irq, a.raise_irq);
        check_field("irq_vector_out", e.irq_vector_out, a.irq_vector_out);
        check_field("aeoi_flag", e.aeoi_flag, a.aeoi_flag);
        check_field("msg_timer_number", e.msg_timer_number, a.msg_timer_number);
        check_field("msg_expiry", e.msg_expiry, a.msg_expiry);
        check_field("msg_delivery", e.msg_delivery, a.msg_delivery);
    endtask

    // Both channels sampled at the rising edge, before the block's own updates.
    // Accepted items go through the shadow model first, so the order holds even
    // if an item and its result were ever to move in the same cycle.
    always @(posedge i_clk) begin
        t_out_item e;
        if (in_ch.valid && in_ch.ready) begin
            e = synic_response(in_ch.payload);
            due_resp.push_back(cur_typed ? cur_typed_resp : e);
            n_items++;
            func_seen[in_ch.payload.func]++;
            if (e.raise_irq) n_irq++;
            if (e.set_slot_pending) n_mark++;
            if (e.status == ST_EXC) n_exc++;
        end
        if (out_ch.valid && out_ch.ready) begin
            n_results++;
            if (due_resp.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("Unexpected result at %0t: %p", $realtime, out_ch.payload);
            end else begin
                check_result(due_resp.pop_front(), out_ch.payload);
            end
        end
    end

    // Watchdog: a quiet stretch as long as STALL_LIMIT, with nothing accepted on either side, ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, due_resp.size());
        $display("Verification failed");
        $finish;
    end

    // Receiver: random back-pressure, calm stretches, and on request a long
    // hold-off counted here so the sender keeps offering into a full block.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= GAP_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offer one item from the falling edge, with random gaps before it; once
    // raised, valid holds until the item is taken.
    task automatic push_item(input t_in_item it, input bit typed, input t_out_item want);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < GAP_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        cur_typed = typed;
        cur_typed_resp = want;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Write the enable only with the block empty: all results in, then a margin of
    // DRAIN_CYCLES more for the pipeline to settle.
    task automatic set_enable(input logic v);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (due_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        enable_q = v;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_dir_row dir_tab [$];
        logic [63:0] ones;
        ones = '1;

        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        cur_typed = 1'b0;
        cur_typed_resp = '0;
        fails = 0;
        n_items = 0; n_results = 0; n_irq = 0; n_mark = 0; n_exc = 0; n_cfg = 0;
        foreach (func_seen[i]) func_seen[i] = 0;

        // shadow state after reset: sources masked, nothing mapped or pending
        foreach (sint_q[i]) sint_q[i] = 64'd1 << MASK_BIT;
        foreach (vmap[i]) vmap[i] = NO_SOURCE;
        pend_q = '0;
        scontrol_q = '0;
        siefp_q = '0;
        simp_q = '0;
        vpa_q = '0;
        enable_q = 1'b0;

        // vector pool: both ends of the legal range plus random picks
        vec_pool[0] = SINT_VEC_MIN;
        vec_pool[1] = 8'hFF;
        for (int i = 2; i < 8; i++) vec_pool[i] = 8'($urandom_range(255, 16));

        // Directed table. Rows with a fixed answer carry it; the rest go to the
        // shadow model.
        // enable clear: gated registers fault, VP assist does not, APIC ones forward but an EOI read faults
        dir_tab.push_back('{1'b0, reg_op(FN_READ, R_SCONTROL, '0), 1'b1,
                            status_only(ST_EXC, '0)});
        dir_tab.push_back('{1'b0, reg_op(FN_WRITE, R_SINT0, 64'h20), 1'b1,
                            status_only(ST_EXC, '0)});
        dir_tab.push_back('{1'b0, reg_op(FN_WRITE, R_VPA, ones), 1'b1,
                            status_only(ST_OK, '0)});
        dir_tab.push_back('{1'b0, reg_op(FN_READ, R_VPA, '0), 1'b1,
                            status_only(ST_OK, ones)});
        dir_tab.push_back('{1'b0, reg_op(FN_READ, R_EOI, '0), 1'b1,
                            status_only(ST_EXC, '0)});
        dir_tab.push_back('{1'b0, reg_op(FN_WRITE, R_EOI, ones), 1'b1,
                            status_only(ST_FWD, '0)});
        dir_tab.push_back('{1'b0, reg_op(FN_WRITE, R_TPR, '0), 1'b1,
                            status_only(ST_FWD, '0)});
        // masked source after reset: delivered, no interrupt; not gated by enable
        dir_tab.push_back('{1'b0, msg_op(4'd0, 1'b0, ones), 1'b0, '0});
        dir_tab.push_back('{1'b0, reg_op(FN_SPARE, '0, '0), 1'b1, status_only(ST_EXC, '0)});
        // enable set
        dir_tab.push_back('{1'b1, reg_op(FN_READ, R_SVERSION, '0), 1'b1,
                            status_only(ST_OK, SVERSION_VAL)});
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_SVERSION, ones), 1'b1,
                            status_only(ST_EXC, '0)});
        // vector below the floor is refused and changes nothing
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_SINT0 + 32'd3, 64'h0F), 1'b1,
                            status_only(ST_EXC, '0)});
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_SINT0 + 32'd3, 64'h2_0010), 1'b1,
                            status_only(ST_OK, '0)});
        dir_tab.push_back('{1'b1, vec_op(FN_QUERY, 8'h10), 1'b0, '0});
        // busy slot marks pending; a second message then finds it pending
        dir_tab.push_back('{1'b1, msg_op(4'd3, 1'b1, '0), 1'b0, '0});
        dir_tab.push_back('{1'b1, msg_op(4'd3, 1'b0, ones), 1'b0, '0});
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_EOM, '0), 1'b1, status_only(ST_OK, '0)});
        dir_tab.push_back('{1'b1, msg_op(4'd3, 1'b0, ones), 1'b0, '0});
        // two sources on one vector, then the first moves away: the map entry
        // is dropped although the other source still uses it
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_SINT0 + 32'd15, 64'hFFFF_FFFF_FFFF_FF10),
                            1'b1, status_only(ST_OK, '0)});
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_SINT0 + 32'd3, 64'hFF), 1'b1,
                            status_only(ST_OK, '0)});
        dir_tab.push_back('{1'b1, vec_op(FN_QUERY, 8'h10), 1'b0, '0});
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_SINT0 + 32'd16, 64'h20), 1'b1,
                            status_only(ST_EXC, '0)});
        dir_tab.push_back('{1'b1, reg_op(FN_READ, R_EOM, '0), 1'b1, status_only(ST_OK, '0)});
        // polling bit on rewrite clears the source's pending bit
        dir_tab.push_back('{1'b1, msg_op(4'd15, 1'b1, ones), 1'b0, '0});
        dir_tab.push_back('{1'b1, reg_op(FN_WRITE, R_SINT0 + 32'd15, 64'h4_0020), 1'b1,
                            status_only(ST_OK, '0)});
        dir_tab.push_back('{1'b1, msg_op(4'd15, 1'b0, ones), 1'b0, '0});

        // hold the synchronous reset, then release it
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_enable(1'b0);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].en != enable_q) set_enable(dir_tab[i].en);
            push_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases under varying enable settings; one runs with no
        // idling, two carry a long receiver hold-off part way through.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_enable(PHASE_EN[ph]);
            calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 120 && (ph == 0 || ph == 3)) hold_req = 1'b1;
                push_item(rand_item(), 1'b0, '0);
            end
            calm = 1'b0;
        end

        // drain, then a tail of TAIL_CYCLES to catch any stray result
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (due_resp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $write("Summary: %0d items (%0d writes, %0d reads, %0d deliveries, ",
               n_items, func_seen[FN_WRITE], func_seen[FN_READ], func_seen[FN_DELIVER]);
        $display("%0d queries, %0d acks, %0d unused codes), %0d results checked",
                 func_seen[FN_QUERY], func_seen[FN_ACK],
                 func_seen[5] + func_seen[6] + func_seen[7], n_results);
        $write("Summary: %0d interrupts raised, %0d slot-pending marks, ", n_irq, n_mark);
        $display("%0d exceptions, %0d enable writes, %0d mismatches", n_exc, n_cfg, fails);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/sic_pkg.sv
rtl/core/sic_chan_if.sv
rtl/core/sic_ram.sv
rtl/core/sic_ctrl.sv
rtl/core/sic_datapath.sv
rtl/core/synthetic_interrupt_controller.sv
dv/synthetic_interrupt_controller_test.sv
